FILE: rtl/indexed_list_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_CORE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ile assertion failed");
`define ILE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ile assertion failed");
`else
`define ILE_ASSERT_SAME(label, clk, rstn, ante, cons)
`define ILE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list engine package
// Command codes, status codes and the result word type.
// ----------------------------------------------------------------------------
package ile_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_REMOVE    = 3'd2,
        CMD_OVERWRITE = 3'd3,
        CMD_READ      = 3'd4,
        CMD_FIND      = 3'd5
    } ile_cmd_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BEYOND   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [31:0] result_value;
        logic [3:0]  result_position;
        logic [2:0]  status;
        logic [4:0]  entry_total;
    } ile_result_t;

endpackage

FILE: rtl/ile_out_reg.sv
// ----------------------------------------------------------------------------
// Indexed list engine output register
// Holds one result word until the master side takes it.
// ----------------------------------------------------------------------------
module ile_out_reg
    import ile_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ile_result_t res,
    output logic        push_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_value, result_position, entry_total, zero pad
    output logic [7:0]  m_tuser    // status, zero pad
);

    logic        valid_reg;
    ile_result_t data_reg;

    assign push_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push && push_ready) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && push_ready) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg.entry_total, data_reg.result_position,
                       data_reg.result_value};
    assign m_tuser  = {5'd0, data_reg.status};

endmodule

FILE: rtl/indexed_list_engine_core.sv
// ----------------------------------------------------------------------------
// Indexed list engine core
// Ordered list of signed 32-bit values in one RAM, walked by a sequencer.
// Each command passes S_DECODE, then S_WALK (insert, remove, find) or S_RDWAIT
//   (read) where needed, then S_DONE; append, overwrite, refusals and unused
//   codes go straight to S_DONE. A new command is taken only in S_IDLE, after
//   the last result is pushed into the output register; walks read one entry a cycle.
// Reset: synchronous active-low aresetn empties the list and drops the output.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_core_defines.svh"

module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_value, position, zero pad
    input  logic [7:0]  s_tuser,   // cmd, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_value, result_position, entry_total, zero pad
    output logic [7:0]  m_tuser    // status, zero pad
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = (CW > 4) ? CW : 4;
    localparam int YW = (CW > 5) ? CW : 5;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WALK   = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [31:0] val_reg;
    logic [3:0]  pos_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic        pend_reg, pend_next;
    ile_result_t res_reg, res_next;

    logic [31:0] values_mem [LIST_DEPTH];
    logic [31:0] rd_data_reg;
    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0] wr_data;

    logic          accept, push, push_ready;
    ile_result_t   push_res;
    logic          empty, full, beyond;
    logic [XW-1:0] pos_x, cnt_x, cnt_m1_x, wa_x;
    logic [YW-1:0] cnt_y;
    logic [CW-1:0] cnt_m1, pos_cw;
    logic [AW-1:0] pos_a, cnt_a, cnt_m1_a;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(LIST_DEPTH));
    assign pos_x    = XW'(pos_reg);
    assign cnt_x    = XW'(count_reg);
    assign beyond   = (pos_x >= cnt_x);
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m1_x = XW'(cnt_m1);
    assign cnt_m1_a = AW'(cnt_m1);
    assign pos_cw   = CW'(pos_reg);
    assign pos_a    = AW'(pos_reg);
    assign cnt_a    = AW'(count_reg);
    assign wa_x     = XW'(wa_reg);
    assign cnt_y    = YW'(count_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            values_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= values_mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = wa_reg;
        wr_data    = rd_data_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        push       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next   = '0;
                pend_next  = 1'b0;
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_APPEND, CMD_INSERT: begin
                        if (full) begin
                            res_next.status = ST_FULL;
                        end else if (cmd_reg == CMD_APPEND || empty) begin
                            wr_en      = 1'b1;
                            wr_addr    = cnt_a;
                            wr_data    = val_reg;
                            count_next = count_reg + CW'(1);
                            res_next.result_position = cnt_x[3:0];
                        end else if (beyond) begin
                            res_next.status = ST_BEYOND;
                        end else begin
                            idx_next   = cnt_m1_a;
                            rem_next   = count_reg - pos_cw;
                            state_next = S_WALK;
                        end
                    end
                    CMD_REMOVE: begin
                        if (empty) begin
                            res_next.status = ST_EMPTY;
                        end else if (beyond) begin
                            res_next.status = ST_BEYOND;
                        end else begin
                            idx_next   = pos_a + AW'(1);
                            rem_next   = cnt_m1 - pos_cw;
                            state_next = S_WALK;
                        end
                    end
                    CMD_OVERWRITE: begin
                        if (empty) begin
                            res_next.status = ST_EMPTY;
                        end else if (beyond) begin
                            res_next.status = ST_BEYOND;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = pos_a;
                            wr_data = val_reg;
                        end
                    end
                    CMD_READ: begin
                        if (empty) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            rd_en           = 1'b1;
                            rd_addr         = beyond ? cnt_m1_a : pos_a;
                            res_next.status = beyond ? ST_BEYOND : ST_OK;
                            state_next      = S_RDWAIT;
                        end
                    end
                    CMD_FIND: begin
                        if (empty) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            idx_next   = '0;
                            rem_next   = count_reg;
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                case (cmd_reg)
                    CMD_INSERT: begin
                        wr_en = pend_reg;
                        if (rem_reg != '0) begin
                            rd_en     = 1'b1;
                            pend_next = 1'b1;
                            wa_next   = idx_reg + AW'(1);
                            idx_next  = idx_reg - AW'(1);
                            rem_next  = rem_reg - CW'(1);
                        end else if (pend_reg) begin
                            pend_next = 1'b0;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = pos_a;
                            wr_data    = val_reg;
                            count_next = count_reg + CW'(1);
                            res_next.result_position = pos_reg;
                            state_next = S_DONE;
                        end
                    end
                    CMD_REMOVE: begin
                        wr_en = pend_reg;
                        if (rem_reg != '0) begin
                            rd_en     = 1'b1;
                            pend_next = 1'b1;
                            wa_next   = idx_reg - AW'(1);
                            idx_next  = idx_reg + AW'(1);
                            rem_next  = rem_reg - CW'(1);
                        end else if (pend_reg) begin
                            pend_next = 1'b0;
                        end else begin
                            count_next = cnt_m1;
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        if (pend_reg && rd_data_reg == val_reg) begin
                            res_next.result_position = wa_x[3:0];
                            state_next = S_DONE;
                        end else if (rem_reg != '0) begin
                            rd_en     = 1'b1;
                            pend_next = 1'b1;
                            wa_next   = idx_reg;
                            idx_next  = idx_reg + AW'(1);
                            rem_next  = rem_reg - CW'(1);
                        end else if (pend_reg) begin
                            pend_next = 1'b0;
                        end else begin
                            res_next.result_position = cnt_m1_x[3:0];
                            res_next.status          = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                res_next.result_value = rd_data_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (push_ready) begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tuser[2:0];
            val_reg <= s_tdata[31:0];
            pos_reg <= s_tdata[35:32];
        end
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        wa_reg  <= wa_next;
        res_reg <= res_next;
    end

    always_comb begin
        push_res             = res_reg;
        push_res.entry_total = cnt_y[4:0];
    end

    ile_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .res        (push_res),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `ILE_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(LIST_DEPTH))
    `ILE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    `ILE_ASSERT_NEXT(a_result_held, aclk, aresetn, state_reg == S_DONE && !push_ready, state_reg == S_DONE)

endmodule

FILE: sim/tb_indexed_list_engine_core.sv
// ----------------------------------------------------------------------------
// Indexed list engine core testbench
// Streams list commands through the core with random source gaps and sink
// stalls. Expected results come from a behavioral list kept alongside. Each
// result word is checked field by field, in order. The run opens with a
// directed sequence covering the corner cases. Random commands follow, in
// grow, shrink and mixed phases, so the list often reaches full and empty.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_core;
    import ile_pkg::*;

    localparam int LIST_DEPTH    = 16;
    localparam int RANDOM_CMDS   = 820;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_MAX    = 10;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} list_mode_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] value;
        logic [3:0]  pos;
        int          gap;
        bit          drain;
    } list_cmd_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [7:0]  m_tuser;

    list_cmd_t   pending_cmds[$];
    ile_result_t expected_results[$];

    logic [31:0] list_vals[LIST_DEPTH];
    int          list_len = 0;

    logic [31:0] value_pool[8];
    bit          src_calm  = 1'b0;
    bit          sink_calm = 1'b0;
    int          gap_count = 0;
    int          stall_left = 0;
    int          stall;
    int          words_sent = 0;
    int          words_back = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          run_over = 1'b0;

    indexed_list_engine_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // behavioral list: applies one command, returns the result word it gives
    function automatic ile_result_t apply_list_cmd(logic [2:0] op, logic [31:0] val,
                                                   logic [3:0] pos);
        ile_result_t r;
        bit          hit;
        r        = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        case (op)
            CMD_APPEND, CMD_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == CMD_APPEND || list_len == 0) begin
                    list_vals[list_len] = val;
                    r.result_position   = 4'(list_len);
                    list_len++;
                end else if (pos >= list_len) begin
                    r.status = ST_BEYOND;
                end else begin
                    for (int i = list_len; i > pos; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[pos]    = val;
                    r.result_position = pos;
                    list_len++;
                end
            end
            CMD_REMOVE, CMD_OVERWRITE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_BEYOND;
                end else if (op == CMD_OVERWRITE) begin
                    list_vals[pos] = val;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.result_value = list_vals[list_len - 1];
                    r.status       = ST_BEYOND;
                end else begin
                    r.result_value = list_vals[pos];
                end
            end
            CMD_FIND: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        if (!hit && list_vals[i] == val) begin
                            hit               = 1'b1;
                            r.result_position = 4'(i);
                        end
                    end
                    if (!hit) begin
                        r.result_position = 4'(list_len - 1);
                        r.status          = ST_NOTFOUND;
                    end
                end
            end
            default: ;
        endcase
        r.entry_total = 5'(list_len);
        return r;
    endfunction

    task automatic add_cmd(logic [2:0] op, logic [31:0] val, logic [3:0] pos, bit drain);
        list_cmd_t c;
        if ($urandom_range(0, 31) == 0)
            src_calm = !src_calm;
        c.op    = op;
        c.value = val;
        c.pos   = pos;
        c.gap   = src_calm ? 0 : $urandom_range(0, 15);
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [2:0] pick_op(list_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return roll[0] ? OP_SPARE_B : OP_SPARE_A;
        case (mode)
            MODE_GROW:   return roll < 45 ? CMD_APPEND : roll < 75 ? CMD_INSERT
                                          : 3'($urandom_range(CMD_REMOVE, CMD_FIND));
            MODE_SHRINK: return roll < 55 ? CMD_REMOVE : roll < 65 ? CMD_INSERT
                                          : 3'($urandom_range(CMD_OVERWRITE, CMD_FIND));
            default:     return 3'($urandom_range(CMD_APPEND, CMD_FIND));
        endcase
    endfunction

    // stimulus
    initial begin
        list_mode_t  mode;
        logic [31:0] val;
        logic [3:0]  pos;
        mode = MODE_GROW;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h0000_0001;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        value_pool[4] = 32'h7FFF_FFFF;
        for (int i = 5; i < 8; i++)
            value_pool[i] = $urandom;

        // directed cases, starting on the empty list
        add_cmd(CMD_READ,      32'h0,         4'd0,  1'b0);
        add_cmd(CMD_FIND,      32'h5,         4'd0,  1'b0);
        add_cmd(CMD_REMOVE,    32'h0,         4'd0,  1'b0);
        add_cmd(CMD_OVERWRITE, 32'h1,         4'd0,  1'b0);
        add_cmd(CMD_INSERT,    32'h7FFF_FFFF, 4'd9,  1'b0);
        add_cmd(CMD_APPEND,    32'h8000_0000, 4'd15, 1'b0);
        add_cmd(CMD_APPEND,    32'h0000_0000, 4'd0,  1'b0);
        add_cmd(CMD_APPEND,    32'hFFFF_FFFF, 4'd3,  1'b0);
        add_cmd(CMD_INSERT,    32'h1111_1111, 4'd4,  1'b0);
        add_cmd(CMD_INSERT,    32'h1234_5678, 4'd0,  1'b0);
        add_cmd(CMD_INSERT,    32'h5A5A_5A5A, 4'd2,  1'b0);
        add_cmd(CMD_READ,      32'h0,         4'd15, 1'b0);
        add_cmd(CMD_READ,      32'h0,         4'd0,  1'b0);
        add_cmd(CMD_FIND,      32'h8000_0000, 4'd0,  1'b0);
        add_cmd(CMD_FIND,      32'h00C0_FFEE, 4'd7,  1'b0);
        add_cmd(CMD_OVERWRITE, 32'h2222_2222, 4'd15, 1'b0);
        add_cmd(CMD_OVERWRITE, 32'hFFFF_FFFF, 4'd1,  1'b0);
        add_cmd(CMD_REMOVE,    32'h0,         4'd14, 1'b0);
        add_cmd(CMD_REMOVE,    32'h0,         4'd0,  1'b0);
        add_cmd(CMD_REMOVE,    32'h0,         4'd4,  1'b0);
        add_cmd(OP_SPARE_A,    32'hFFFF_FFFF, 4'd15, 1'b0);
        add_cmd(OP_SPARE_B,    32'h8000_0001, 4'd8,  1'b0);
        add_cmd(CMD_APPEND,    32'hA5A5_A5A5, 4'd5,  1'b1);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 40 == 0)
                mode = list_mode_t'($urandom_range(MODE_GROW, MODE_MIXED));
            val = ($urandom_range(0, 3) == 0) ? $urandom : value_pool[$urandom_range(0, 7)];
            pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
            add_cmd(pick_op(mode), val, pos, $urandom_range(0, 99) == 0);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || words_sent != words_back)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0) begin
            $display("%0d expected result words never arrived", expected_results.size());
            mismatches += expected_results.size();
        end
        run_over = 1'b1;
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            gap_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(
                    apply_list_cmd(s_tuser[2:0], s_tdata[31:0], s_tdata[35:32]));
                words_sent <= words_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (gap_count < pending_cmds[0].gap) begin
                    gap_count <= gap_count + 1;
                    s_tvalid  <= 1'b0;
                end else if (pending_cmds[0].drain && (s_tvalid || words_sent != words_back)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {4'b0, pending_cmds[0].pos, pending_cmds[0].value};
                    s_tuser   <= {5'b0, pending_cmds[0].op};
                    gap_count <= 0;
                    void'(pending_cmds.pop_front());
                end
            end
        end
    end

    // sink side and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_back <= words_back + 1;
                if (expected_results.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected result word: value %h pos %0d status %0d total %0d",
                                 m_tdata[31:0], m_tdata[35:32], m_tuser[2:0], m_tdata[40:36]);
                    mismatches++;
                end else begin
                    if (m_tdata[31:0]  !== expected_results[0].result_value
                     || m_tdata[35:32] !== expected_results[0].result_position
                     || m_tdata[40:36] !== expected_results[0].entry_total
                     || m_tuser[2:0]   !== expected_results[0].status) begin
                        if (mismatches < REPORT_MAX) begin
                            $write("word %0d mismatch: exp value %h pos %0d status %0d total %0d, ",
                                   words_back,
                                   expected_results[0].result_value,
                                   expected_results[0].result_position,
                                   expected_results[0].status,
                                   expected_results[0].entry_total);
                            $display("got value %h pos %0d status %0d total %0d",
                                     m_tdata[31:0], m_tdata[35:32], m_tuser[2:0],
                                     m_tdata[40:36]);
                        end
                        mismatches++;
                    end
                    void'(expected_results.pop_front());
                end
                if ($urandom_range(0, 31) == 0)
                    sink_calm = !sink_calm;
                stall = sink_calm ? 0 : $urandom_range(0, 15);
                stall_left <= stall;
                m_tready   <= (stall == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= (stall_left == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn && !run_over) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
